/* design/cmgh_pkg.sv */
// cmgh_pkg: shared types, codes and defaults for color_matrix_gamma_histogram
// no dependencies
package cmgh_pkg;

    localparam int TONE_INDEX_BITS_DEF    = 16;
    localparam int COEF_FRACTION_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF         = 24;
    localparam int BIN_COUNT_DEF          = 256;

    localparam int SAMPLE_BITS   = 16;
    localparam int COEF_BITS     = 16;
    localparam int ROW_BITS      = 48;
    localparam int TONE_BITS     = 8;
    localparam int BIN_OUT_BITS  = 24;
    localparam int CHANNELS      = 3;

    localparam logic [ROW_BITS-1:0] RED_ROW_RESET   = 48'd256;
    localparam logic [ROW_BITS-1:0] GREEN_ROW_RESET = 48'd16777216;
    localparam logic [ROW_BITS-1:0] BLUE_ROW_RESET  = 48'd1099511627776;

    typedef enum logic [1:0] {
        OP_PIXEL       = 2'd0,
        OP_TABLE_WRITE = 2'd1,
        OP_BIN_READ    = 2'd2,
        OP_HIST_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_RED_ROW   = 2'd0,
        CFG_GREEN_ROW = 2'd1,
        CFG_BLUE_ROW  = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_TONE,
        ST_HIST,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] table_index;
        logic [7:0]  table_value;
        logic [1:0]  hist_channel;
        logic [7:0]  hist_bin;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [23:0] bin_count;
    } t_out_word;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_en;

endpackage

/* design/cmgh_ram.sv */
// cmgh_ram: one write port, one read port memory with registered read data
// uses cmgh_pkg for the port enable struct
module cmgh_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DEPTH     = 256,
    parameter int DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  cmgh_pkg::t_mem_en    i_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);
    import cmgh_pkg::*;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_en.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/cmgh_csc.sv */
// cmgh_csc: one matrix row against the pixel, products registered, then sum and clamp
// uses cmgh_pkg for sample and coefficient widths
module cmgh_csc #(
    parameter int COEF_FRACTION_BITS = cmgh_pkg::COEF_FRACTION_BITS_DEF
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_mul_en,
    input  logic [cmgh_pkg::CHANNELS-1:0][cmgh_pkg::SAMPLE_BITS-1:0] i_samples,
    input  logic [cmgh_pkg::ROW_BITS-1:0]                          i_row,
    output logic [cmgh_pkg::SAMPLE_BITS-1:0]                       o_lin
);
    import cmgh_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + 1 + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    logic signed [PROD_BITS-1:0] r_prod [CHANNELS];
    logic signed [SUM_BITS-1:0]  sum;
    logic signed [SUM_BITS-1:0]  shifted;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_prod[k] <= PROD_BITS'(signed'({1'b0, i_samples[k]}))
                           * PROD_BITS'(signed'(i_row[k*COEF_BITS +: COEF_BITS]));
            end
        end
    end

    always_comb begin
        sum     = SUM_BITS'(r_prod[0]) + SUM_BITS'(r_prod[1]) + SUM_BITS'(r_prod[2]);
        shifted = sum >>> COEF_FRACTION_BITS;
        if (sum[SUM_BITS-1]) begin
            o_lin = '0;
        end else if (shifted > SUM_BITS'(65535)) begin
            o_lin = '1;
        end else begin
            o_lin = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

/* design/color_matrix_gamma_histogram.sv */
// color_matrix_gamma_histogram: color matrix, tone table and per-channel histogram
// uses cmgh_pkg, cmgh_ram (tone table and histogram rows), cmgh_csc (matrix row)
//
// channel   valid     stall     payload    accepted when
// input     i_valid   o_stall   i_word     i_valid & !o_stall
// output    o_valid   i_stall   o_word     o_valid & !i_stall
// config    i_cfg_wr_en  -      i_cfg_index, i_cfg_data   i_cfg_wr_en
//
// a pixel word passes its three channels one after another through
// the shared matrix row unit, the tone table read port and the histogram row port
// a table write completes as the word is taken; a clear reruns the clearing pass
// after reset a clearing pass zeroes every histogram bin, o_stall high
// a finished word waits in the output register while the next word is taken
module color_matrix_gamma_histogram #(
    parameter int TONE_INDEX_BITS    = cmgh_pkg::TONE_INDEX_BITS_DEF,
    parameter int COEF_FRACTION_BITS = cmgh_pkg::COEF_FRACTION_BITS_DEF,
    parameter int COUNT_BITS         = cmgh_pkg::COUNT_BITS_DEF,
    parameter int BIN_COUNT          = cmgh_pkg::BIN_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  cmgh_pkg::t_in_word            i_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output cmgh_pkg::t_out_word           o_word,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [cmgh_pkg::ROW_BITS-1:0] i_cfg_data
);
    import cmgh_pkg::*;

    localparam int BIN_BITS  = $clog2(BIN_COUNT);
    localparam int HROW_BITS = CHANNELS * COUNT_BITS;

    t_state                               r_state, n_state;
    logic [1:0]                           r_chan, n_chan;
    t_in_word                             r_word, n_word;
    logic [CHANNELS-1:0][TONE_BITS-1:0]   r_toned, n_toned;
    logic [BIN_BITS-1:0]                  r_bin, n_bin;
    logic [BIN_BITS-1:0]                  r_clr_addr, n_clr_addr;
    logic                                 r_out_valid, n_out_valid;
    t_out_word                            r_out, n_out;
    logic [CHANNELS-1:0][ROW_BITS-1:0]    r_coef;

    logic                                 in_accept;
    logic                                 out_free;
    logic                                 mul_en;
    logic [SAMPLE_BITS-1:0]               lin;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samples;

    t_mem_en                              tone_en;
    logic [TONE_INDEX_BITS-1:0]           tone_rd_addr;
    logic [TONE_BITS-1:0]                 tone_q;

    t_mem_en                              hist_en;
    logic [BIN_BITS-1:0]                  hist_wr_addr;
    logic [BIN_BITS-1:0]                  hist_rd_addr;
    logic [HROW_BITS-1:0]                 hist_wr_data;
    logic [HROW_BITS-1:0]                 hist_q;

    logic [16:0]                          bin_prod;
    logic [COUNT_BITS-1:0]                cnt_old;
    logic [COUNT_BITS-1:0]                cnt_sel;
    logic [31:0]                          cnt_wide;
    logic                                 read_ok;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= RED_ROW_RESET;
            r_coef[1] <= GREEN_ROW_RESET;
            r_coef[2] <= BLUE_ROW_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_RED_ROW:   r_coef[0] <= i_cfg_data;
                CFG_GREEN_ROW: r_coef[1] <= i_cfg_data;
                CFG_BLUE_ROW:  r_coef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign samples  = {r_word.blue_in, r_word.green_in, r_word.red_in};
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;

    cmgh_csc #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
    ) u_csc (
        .i_clk     (i_clk),
        .i_mul_en  (mul_en),
        .i_samples (samples),
        .i_row     (r_coef[r_chan]),
        .o_lin     (lin)
    );

    cmgh_ram #(
        .ADDR_BITS(TONE_INDEX_BITS),
        .DEPTH    (2 ** TONE_INDEX_BITS),
        .DATA_BITS(TONE_BITS)
    ) u_tone_ram (
        .i_clk     (i_clk),
        .i_en      (tone_en),
        .i_wr_addr (i_word.table_index[TONE_INDEX_BITS-1:0]),
        .i_wr_data (i_word.table_value),
        .i_rd_addr (tone_rd_addr),
        .o_rd_data (tone_q)
    );

    cmgh_ram #(
        .ADDR_BITS(BIN_BITS),
        .DEPTH    (BIN_COUNT),
        .DATA_BITS(HROW_BITS)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_en      (hist_en),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (hist_wr_data),
        .i_rd_addr (hist_rd_addr),
        .o_rd_data (hist_q)
    );

    assign tone_rd_addr = lin[SAMPLE_BITS-1 -: TONE_INDEX_BITS];
    assign bin_prod     = 17'(tone_q) * 17'(BIN_COUNT);
    assign cnt_old      = hist_q[r_chan*COUNT_BITS +: COUNT_BITS];
    assign read_ok      = (9'(r_word.hist_bin) < 9'(BIN_COUNT));

    always_comb begin
        case (r_word.hist_channel)
            2'd0:    cnt_sel = hist_q[0 +: COUNT_BITS];
            2'd1:    cnt_sel = hist_q[COUNT_BITS +: COUNT_BITS];
            2'd2:    cnt_sel = hist_q[2*COUNT_BITS +: COUNT_BITS];
            default: cnt_sel = '0;
        endcase
        if (!read_ok) begin
            cnt_sel = '0;
        end
        cnt_wide = 32'(cnt_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_chan      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_toned <= n_toned;
        r_bin   <= n_bin;
        r_out   <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_chan       = r_chan;
        n_word       = r_word;
        n_toned      = r_toned;
        n_bin        = r_bin;
        n_clr_addr   = r_clr_addr;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_stall;
        o_stall      = 1'b1;
        mul_en       = 1'b0;
        tone_en      = '0;
        hist_en      = '0;
        hist_rd_addr = r_bin;
        hist_wr_addr = r_bin;
        hist_wr_data = hist_q;

        unique case (r_state)
            ST_CLEAR: begin
                hist_en.wr   = 1'b1;
                hist_wr_addr = r_clr_addr;
                hist_wr_data = '0;
                n_clr_addr   = r_clr_addr + 1'b1;
                if (r_clr_addr == BIN_BITS'(BIN_COUNT - 1)) begin
                    n_clr_addr = '0;
                    n_state    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (in_accept) begin
                    n_word = i_word;
                    unique case (i_word.op)
                        OP_PIXEL: begin
                            n_chan  = '0;
                            n_state = ST_MUL;
                        end
                        OP_TABLE_WRITE: begin
                            tone_en.wr = 1'b1;
                        end
                        OP_BIN_READ: begin
                            hist_en.rd   = 1'b1;
                            hist_rd_addr = i_word.hist_bin[BIN_BITS-1:0];
                            n_state      = ST_READ;
                        end
                        OP_HIST_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                mul_en  = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                tone_en.rd = 1'b1;
                n_state    = ST_TONE;
            end
            ST_TONE: begin
                n_toned[r_chan] = tone_q;
                n_bin           = bin_prod[8 +: BIN_BITS];
                hist_en.rd      = 1'b1;
                hist_rd_addr    = bin_prod[8 +: BIN_BITS];
                n_state         = ST_HIST;
            end
            ST_HIST: begin
                // saturating count, other channels of the row kept
                hist_en.wr = 1'b1;
                if (cnt_old != '1) begin
                    hist_wr_data[r_chan*COUNT_BITS +: COUNT_BITS] = cnt_old + 1'b1;
                end
                if (r_chan == 2'd2) begin
                    n_state = ST_DONE;
                end else begin
                    n_chan  = r_chan + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.red_out   = r_toned[0];
                    n_out.green_out = r_toned[1];
                    n_out.blue_out  = r_toned[2];
                    n_out.bin_count = '0;
                    n_state         = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.red_out   = '0;
                    n_out.green_out = '0;
                    n_out.blue_out  = '0;
                    n_out.bin_count = cnt_wide[BIN_OUT_BITS-1:0];
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

/* tb/sv/cmgh_checker.sv */
`timescale 1ns / 1ps
// cmgh_checker: watches the word, result and config channels of color_matrix_gamma_histogram,
// predicts each result from its own matrix rows, tone table and histogram, compares in order
// depends on cmgh_pkg
module cmgh_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  cmgh_pkg::t_in_word            i_in_word,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  cmgh_pkg::t_out_word           i_out_word,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [cmgh_pkg::ROW_BITS-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results
);
    import cmgh_pkg::*;

    logic [ROW_BITS-1:0]     coef_row [CHANNELS];
    logic [TONE_BITS-1:0]    tone_lut [0:(1 << TONE_INDEX_BITS_DEF) - 1];
    logic [COUNT_BITS_DEF-1:0] hist_count [CHANNELS][BIN_COUNT_DEF];
    t_out_word               expected_q [$];
    int                      fails = 0;
    int                      checked = 0;

    function automatic logic [SAMPLE_BITS-1:0] matrix_channel(input logic [ROW_BITS-1:0] row,
                                                              input t_in_word w);
        logic signed [COEF_BITS-1:0] k_red, k_green, k_blue;
        longint c_red, c_green, c_blue, s_red, s_green, s_blue, acc;
        k_red   = row[15:0];
        k_green = row[31:16];
        k_blue  = row[47:32];
        c_red   = k_red;
        c_green = k_green;
        c_blue  = k_blue;
        s_red   = w.red_in;
        s_green = w.green_in;
        s_blue  = w.blue_in;
        acc = c_red * s_red + c_green * s_green + c_blue * s_blue;
        // arithmetic shift floors toward minus infinity
        acc = acc >>> COEF_FRACTION_BITS_DEF;
        if (acc < 0) return '0;
        if (acc > 65535) return '1;
        return acc[SAMPLE_BITS-1:0];
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : model_update
        t_out_word            want_w;
        t_out_word            new_w;
        logic [SAMPLE_BITS-1:0] lin;
        logic [TONE_BITS-1:0] toned [CHANNELS];
        int                   bin_idx;
        if (!i_rst_n) begin
            coef_row[0] = RED_ROW_RESET;
            coef_row[1] = GREEN_ROW_RESET;
            coef_row[2] = BLUE_ROW_RESET;
            for (int c = 0; c < CHANNELS; c++)
                for (int b = 0; b < BIN_COUNT_DEF; b++)
                    hist_count[c][b] = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_RED_ROW:   coef_row[0] = i_cfg_data;
                    CFG_GREEN_ROW: coef_row[1] = i_cfg_data;
                    CFG_BLUE_ROW:  coef_row[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time,
                             i_out_word);
                    fails++;
                end else begin
                    want_w = expected_q.pop_front();
                    check_field("red_out", want_w.red_out, i_out_word.red_out);
                    check_field("green_out", want_w.green_out, i_out_word.green_out);
                    check_field("blue_out", want_w.blue_out, i_out_word.blue_out);
                    check_field("bin_count", want_w.bin_count, i_out_word.bin_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                new_w = '0;
                case (i_in_word.op)
                    OP_PIXEL: begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            lin      = matrix_channel(coef_row[c], i_in_word);
                            toned[c] = tone_lut[lin >> (SAMPLE_BITS - TONE_INDEX_BITS_DEF)];
                            bin_idx  = (int'(toned[c]) * BIN_COUNT_DEF) >> 8;
                            if (hist_count[c][bin_idx] != '1)
                                hist_count[c][bin_idx] = hist_count[c][bin_idx] + 1'b1;
                        end
                        new_w.red_out   = toned[0];
                        new_w.green_out = toned[1];
                        new_w.blue_out  = toned[2];
                        expected_q.push_back(new_w);
                    end
                    OP_TABLE_WRITE: begin
                        tone_lut[i_in_word.table_index] = i_in_word.table_value;
                    end
                    OP_BIN_READ: begin
                        if (i_in_word.hist_channel < CHANNELS && i_in_word.hist_bin < BIN_COUNT_DEF)
                            new_w.bin_count = hist_count[i_in_word.hist_channel][i_in_word.hist_bin];
                        expected_q.push_back(new_w);
                    end
                    default: begin
                        for (int c = 0; c < CHANNELS; c++)
                            for (int b = 0; b < BIN_COUNT_DEF; b++)
                                hist_count[c][b] = '0;
                    end
                endcase
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
        o_results    <= checked;
    end

endmodule

/* tb/sv/tb_color_matrix_gamma_histogram.sv */
`timescale 1ns / 1ps
// tb_color_matrix_gamma_histogram: stimulus, stall patterns, watchdog and verdict for
// color_matrix_gamma_histogram; depends on cmgh_pkg, cmgh_checker and the block itself
module tb_color_matrix_gamma_histogram;
    import cmgh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int QUIET_CYCLES   = 300;
    localparam int TONE_DEPTH     = 1 << TONE_INDEX_BITS_DEF;
    localparam int TOTAL_ITEMS    = 1350;
    localparam int ROW_PERIOD     = 60;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                word_valid  = 1'b0;
    logic                word_stall;
    t_in_word            in_word     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    t_out_word           out_word;
    logic                cfg_wr_en   = 1'b0;
    logic [1:0]          cfg_index   = '0;
    logic [ROW_BITS-1:0] cfg_data    = '0;

    logic [ROW_BITS-1:0] row_now [CHANNELS] = '{RED_ROW_RESET, GREEN_ROW_RESET,
                                                BLUE_ROW_RESET};
    bit                  tone_written [TONE_DEPTH];

    int fail_count;
    int pending;
    int results_seen;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int n_items        = 0;
    int n_pixel        = 0;
    int n_read         = 0;
    int n_write        = 0;
    int n_clear        = 0;
    int n_settings     = 0;

    color_matrix_gamma_histogram i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (word_valid),
        .o_stall     (word_stall),
        .i_word      (in_word),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_word      (out_word),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cmgh_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (word_valid),
        .i_in_stall   (word_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((word_valid && !word_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in_word rand_word(input t_op op);
        t_in_word    w;
        logic [127:0] raw;
        raw  = {$urandom, $urandom, $urandom, $urandom};
        w    = raw[$bits(t_in_word)-1:0];
        w.op = op;
        return w;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] rand_coef();
        case ($urandom_range(8))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3, 4:    return 16'($urandom_range(512)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_BITS-1:0] rand_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // clamped matrix output of one row, used to find the tone entry a pixel hits
    function automatic logic [SAMPLE_BITS-1:0] row_lin(input logic [ROW_BITS-1:0] row,
                                                       input t_in_word w);
        longint acc;
        acc = longint'(signed'(row[15:0])) * longint'(w.red_in)
            + longint'(signed'(row[31:16])) * longint'(w.green_in)
            + longint'(signed'(row[47:32])) * longint'(w.blue_in);
        acc = acc >>> COEF_FRACTION_BITS_DEF;
        if (acc < 0) return '0;
        if (acc > 65535) return '1;
        return acc[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_in_word pixel_word(input logic [15:0] r, input logic [15:0] g,
                                            input logic [15:0] b);
        t_in_word w;
        w          = rand_word(OP_PIXEL);
        w.red_in   = r;
        w.green_in = g;
        w.blue_in  = b;
        return w;
    endfunction

    function automatic t_in_word write_word(input logic [15:0] idx, input logic [7:0] val);
        t_in_word w;
        w             = rand_word(OP_TABLE_WRITE);
        w.table_index = idx;
        w.table_value = val;
        return w;
    endfunction

    function automatic t_in_word read_word(input logic [1:0] ch, input logic [7:0] bin);
        t_in_word w;
        w              = rand_word(OP_BIN_READ);
        w.hist_channel = ch;
        w.hist_bin     = bin;
        return w;
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        in_word    <= w;
        do @(posedge clk); while (word_stall);
        n_items++;
        case (w.op)
            OP_PIXEL:       n_pixel++;
            OP_BIN_READ:    n_read++;
            OP_TABLE_WRITE: begin
                n_write++;
                tone_written[w.table_index] = 1'b1;
            end
            default:        n_clear++;
        endcase
    endtask

    // write any tone entry the pixel looks up that has never been written, then the pixel
    task automatic send_pixel(input t_in_word w);
        logic [SAMPLE_BITS-1:0] lin;
        for (int c = 0; c < CHANNELS; c++) begin
            lin = row_lin(row_now[c], w) >> (SAMPLE_BITS - TONE_INDEX_BITS_DEF);
            if (!tone_written[lin])
                send_word(write_word(lin, 8'($urandom_range(255))));
        end
        send_word(w);
    endtask

    // hold off until every result is in, then leave room for a clear still running
    task automatic settle();
        word_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_rows(input logic [ROW_BITS-1:0] r, input logic [ROW_BITS-1:0] g,
                            input logic [ROW_BITS-1:0] b);
        row_now[0] = r;
        row_now[1] = g;
        row_now[2] = b;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RED_ROW;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= CFG_GREEN_ROW;
        cfg_data  <= g;
        @(posedge clk);
        cfg_index <= CFG_BLUE_ROW;
        cfg_data  <= b;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic send_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_pixel(pixel_word(rand_sample(), rand_sample(), rand_sample()));
        end else if (pick < 80) begin
            send_word(rand_word(OP_BIN_READ));
        end else if (pick < 98) begin
            send_word(rand_word(OP_TABLE_WRITE));
        end else begin
            send_word(rand_word(OP_HIST_CLEAR));
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // wait out the clearing pass
        do @(posedge clk); while (word_stall);

        send_idle_pct  = 20;
        recv_stall_pct = 81;
        set_rows(RED_ROW_RESET, GREEN_ROW_RESET, BLUE_ROW_RESET);

        // both clamp ends of the tone table
        send_word(write_word(16'h0000, 8'h00));
        send_word(write_word(16'hFFFF, 8'hFF));

        send_pixel(pixel_word(16'h0000, 16'h0000, 16'h0000));
        send_pixel(pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pixel_word(16'h8000, 16'h0001, 16'h7FFF));
        send_word(read_word(2'd0, 8'd0));
        send_word(read_word(2'd1, 8'd0));
        send_word(read_word(2'd2, 8'd255));
        send_word(read_word(2'd0, 8'd255));
        send_word(read_word(2'd3, 8'd0));
        send_word(read_word(2'd3, 8'd255));
        send_word(write_word(16'h0000, 8'hA5));
        send_pixel(pixel_word(16'h0000, 16'h0000, 16'h0000));
        send_word(read_word(2'd1, 8'hA5));
        send_word(write_word(16'hFFFF, 8'h00));
        send_pixel(pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(write_word(16'hFFFF, 8'hFF));
        send_word(rand_word(OP_HIST_CLEAR));
        send_word(read_word(2'd0, 8'd0));
        send_word(read_word(2'd2, 8'd255));
        send_pixel(pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(read_word(2'd2, 8'd255));
        settle();
        // largest positive weights, the full-scale pixel clamps high
        set_rows({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_pixel(pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pixel_word(16'h0001, 16'h0000, 16'h0000));
        settle();
        // most negative weights, any nonzero pixel clamps low
        set_rows({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_pixel(pixel_word(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pixel_word(16'h0000, 16'h0000, 16'h0000));
        send_pixel(pixel_word(16'h0001, 16'h0000, 16'h0000));

        for (int phase = 0; phase < 3; phase++) begin
            int sent;
            sent = 0;
            while (n_items < (TOTAL_ITEMS * (phase + 1)) / 3) begin
                if (sent % ROW_PERIOD == 0) begin
                    settle();
                    case (phase)
                        0: begin
                            send_idle_pct  = 20;
                            recv_stall_pct = 81;
                        end
                        1: begin
                            send_idle_pct  = 81;
                            recv_stall_pct = 20;
                        end
                        default: begin
                            send_idle_pct  = 0;
                            recv_stall_pct = 0;
                        end
                    endcase
                    set_rows(rand_row(), rand_row(), rand_row());
                end
                send_random();
                sent++;
            end
        end
        settle();

        $display("covered %0d pixel words, %0d bin reads, %0d table writes, %0d clears",
                 n_pixel, n_read, n_write, n_clear);
        $display("%0d results compared across %0d matrix settings", results_seen, n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
